// ----- rtl/sem_pkg.sv -----
// shared types and constants for the sobel edge magnitude block
// no dependencies; imported by every other rtl file except sem_ram
`default_nettype none

package sem_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT = 2'd1;

    // frame geometry
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;
    localparam int SIZE_MIN     = 3;
    localparam int HEIGHT_MAX   = 4096;
    localparam int ROW_W        = 12;
    localparam int WIDTH_FIELD_W  = 11;
    localparam int HEIGHT_FIELD_W = 13;

    // pixel and gradient widths
    localparam int PIX_W  = 8;
    localparam int GRAD_W = 11;
    localparam int MAG_W  = 10;
    localparam int SQ_W   = 21;
    localparam int PROD_W = 2 * MAG_W;

    localparam logic [PIX_W-1:0] EDGE_MAX = 8'hFF;
    localparam logic [PIX_W-1:0] ROOT_MSB = 8'h80;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic                     last;
    } sem_grad_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
        logic              empty;
    } sem_qstat_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SQX,
        BK_SQY,
        BK_ROOT,
        BK_DONE
    } sem_bk_state_t;

endpackage

`default_nettype wire

// ----- rtl/sem_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module sem_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/sem_front.sv -----
// front part: pixel intake, frame counters, line buffer ram, 3x3 window, gx/gy
// depends on sem_pkg and sem_ram
`default_nettype none

module sem_front
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   pixel_valid,
    output logic                        pixel_stall,
    input  wire logic [PIX_W-1:0]       pixel,
    input  wire sem_qstat_t             qstat,
    output logic                        q_push,
    output sem_grad_t                   q_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int W_RST = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
    localparam int LB_W = 2 * PIX_W;

    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CW-1:0]    wm1_reg, wm1_next;
    logic [ROW_W-1:0] hm1_reg, hm1_next;

    logic             s1_valid_reg;
    logic [CW-1:0]    s1_addr_reg;
    logic [PIX_W-1:0] s1_px_reg;
    logic             s1_emit_reg;
    logic             s1_last_reg;

    logic             wr_valid_reg;
    logic [CW-1:0]    wr_addr_reg;
    logic [LB_W-1:0]  wr_data_reg;

    // window columns: index 0 top, 1 middle, 2 bottom
    logic [PIX_W-1:0] win_a_reg [3];
    logic [PIX_W-1:0] win_b_reg [3];
    logic [PIX_W-1:0] fresh [3];

    logic             accept;
    logic [LB_W-1:0]  ram_rdata;
    logic [LB_W-1:0]  lb_data;
    logic [LB_W-1:0]  lb_wdata;
    logic [GRAD_W-1:0] right_sum, left_sum, bot_sum, top_sum;
    int               w_int, h_int;

    assign pixel_stall = (int'(qstat.count) + int'(s1_valid_reg)) >= QDEPTH;
    assign accept      = pixel_valid && !pixel_stall;

    sem_ram #(
        .WIDTH (LB_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_addr_reg),
        .wdata (lb_wdata),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    // forward the write made at the same edge as this item's read
    assign lb_data  = (wr_valid_reg && (wr_addr_reg == s1_addr_reg)) ? wr_data_reg : ram_rdata;
    assign lb_wdata = {lb_data[PIX_W-1:0], s1_px_reg};

    assign fresh[0] = lb_data[LB_W-1:PIX_W];
    assign fresh[1] = lb_data[PIX_W-1:0];
    assign fresh[2] = s1_px_reg;

    always_comb
    begin
        right_sum = GRAD_W'(fresh[0]) + GRAD_W'({fresh[1], 1'b0}) + GRAD_W'(fresh[2]);
        left_sum  = GRAD_W'(win_a_reg[0]) + GRAD_W'({win_a_reg[1], 1'b0})
                  + GRAD_W'(win_a_reg[2]);
        bot_sum   = GRAD_W'(win_a_reg[2]) + GRAD_W'({win_b_reg[2], 1'b0}) + GRAD_W'(fresh[2]);
        top_sum   = GRAD_W'(win_a_reg[0]) + GRAD_W'({win_b_reg[0], 1'b0}) + GRAD_W'(fresh[0]);
        q_data.gx   = signed'(right_sum - left_sum);
        q_data.gy   = signed'(bot_sum - top_sum);
        q_data.last = s1_last_reg;
    end

    assign q_push = s1_valid_reg && s1_emit_reg;

    // geometry registers hold the clamped size minus one
    always_comb
    begin
        w_int = int'(cfg_data[WIDTH_FIELD_W-1:0]);
        h_int = int'(cfg_data[HEIGHT_FIELD_W-1:0]);
        if (w_int < SIZE_MIN)
        begin
            w_int = SIZE_MIN;
        end
        else if (w_int > MAX_WIDTH)
        begin
            w_int = MAX_WIDTH;
        end
        if (h_int < SIZE_MIN)
        begin
            h_int = SIZE_MIN;
        end
        else if (h_int > HEIGHT_MAX)
        begin
            h_int = HEIGHT_MAX;
        end
        wm1_next = wm1_reg;
        hm1_next = hm1_reg;
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_reg == wm1_reg)
            begin
                col_next = '0;
                row_next = (row_reg == hm1_reg) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
        if (cfg_write && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT))
        begin
            col_next = '0;
            row_next = '0;
            if (cfg_index == REG_WIDTH)
            begin
                wm1_next = CW'(w_int - 1);
            end
            else
            begin
                hm1_next = ROW_W'(h_int - 1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            wm1_reg      <= CW'(W_RST - 1);
            hm1_reg      <= ROW_W'(HEIGHT_RESET - 1);
            s1_valid_reg <= 1'b0;
            wr_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            wm1_reg      <= wm1_next;
            hm1_reg      <= hm1_next;
            s1_valid_reg <= accept;
            wr_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg <= col_reg;
            s1_px_reg   <= pixel;
            s1_emit_reg <= (row_reg >= ROW_W'(2)) && (col_reg >= CW'(2));
            s1_last_reg <= (row_reg == hm1_reg) && (col_reg == wm1_reg);
        end
        if (s1_valid_reg)
        begin
            wr_addr_reg <= s1_addr_reg;
            wr_data_reg <= lb_wdata;
            win_a_reg   <= win_b_reg;
            win_b_reg   <= fresh;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sem_queue.sv -----
// short queue of gradient pairs between the front and back parts
// depends on sem_pkg
`default_nettype none

module sem_queue
    import sem_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire sem_grad_t push_data,
    input  wire logic pop,
    output sem_grad_t head,
    output sem_qstat_t qstat
);

    sem_grad_t         entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign head        = entry_reg[rd_ptr_reg];
    assign qstat.count = count_reg;
    assign qstat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign qstat.empty = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sem_back.sv -----
// back part: squares, bit-serial square root and the output register
// depends on sem_pkg
`default_nettype none

module sem_back
    import sem_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sem_grad_t         head,
    input  wire sem_qstat_t        qstat,
    output logic                   pop,
    output logic                   edge_valid,
    input  wire logic              edge_stall,
    output logic [PIX_W-1:0]       edge_value,
    output logic                   frame_last
);

    sem_bk_state_t     state_reg, state_next;
    logic [MAG_W-1:0]  ax_reg, ax_next, ay_reg, ay_next;
    logic              last_reg, last_next;
    logic [SQ_W-1:0]   acc_reg, acc_next;
    logic [PIX_W-1:0]  root_reg, root_next;
    logic [PIX_W-1:0]  bit_reg, bit_next;
    logic              out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]  out_value_reg, out_value_next;
    logic              out_last_reg, out_last_next;

    logic [MAG_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] prod;
    logic [SQ_W-1:0]   sum;
    logic [PIX_W-1:0]  trial;
    logic [GRAD_W-1:0] gx_abs, gy_abs;

    // one shared multiplier
    assign prod  = mul_a * mul_b;
    assign sum   = acc_reg + SQ_W'(prod);
    assign trial = root_reg | bit_reg;

    assign gx_abs = head.gx[GRAD_W-1] ? GRAD_W'(-head.gx) : GRAD_W'(head.gx);
    assign gy_abs = head.gy[GRAD_W-1] ? GRAD_W'(-head.gy) : GRAD_W'(head.gy);

    assign edge_valid = out_valid_reg;
    assign edge_value = out_value_reg;
    assign frame_last = out_last_reg;

    always_comb
    begin
        state_next     = state_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        last_next      = last_reg;
        acc_next       = acc_reg;
        root_next      = root_reg;
        bit_next       = bit_reg;
        out_valid_next = out_valid_reg && edge_stall;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        pop            = 1'b0;
        mul_a          = ax_reg;
        mul_b          = ax_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!qstat.empty)
                begin
                    pop        = 1'b1;
                    ax_next    = gx_abs[MAG_W-1:0];
                    ay_next    = gy_abs[MAG_W-1:0];
                    last_next  = head.last;
                    state_next = BK_SQX;
                end
            end
            BK_SQX:
            begin
                acc_next   = SQ_W'(prod);
                state_next = BK_SQY;
            end
            BK_SQY:
            begin
                mul_a     = ay_reg;
                mul_b     = ay_reg;
                acc_next  = sum;
                root_next = '0;
                bit_next  = ROOT_MSB;
                if (sum[SQ_W-1:2*PIX_W] != '0)
                begin
                    root_next  = EDGE_MAX;
                    state_next = BK_DONE;
                end
                else
                begin
                    state_next = BK_ROOT;
                end
            end
            BK_ROOT:
            begin
                mul_a    = MAG_W'(trial);
                mul_b    = MAG_W'(trial);
                bit_next = bit_reg >> 1;
                if (prod <= PROD_W'(acc_reg))
                begin
                    root_next = trial;
                end
                if (bit_reg[0])
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (!out_valid_reg || !edge_stall)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = root_reg;
                    out_last_next  = last_reg;
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg        <= ax_next;
        ay_reg        <= ay_next;
        last_reg      <= last_next;
        acc_reg       <= acc_next;
        root_reg      <= root_next;
        bit_reg       <= bit_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

endmodule

`default_nettype wire

// ----- rtl/sobel_edge_magnitude.sv -----
// top level of the sobel 3x3 gradient magnitude block
// depends on sem_pkg, sem_front, sem_queue and sem_back (sem_ram via sem_front)
//
// pixels come in raster order on the pixel channel, one per transfer; every
// interior pixel (row >= 2, column >= 2, counted at the window's bottom-right
// corner) gives one transfer on the edge channel carrying floor(sqrt(gx^2+gy^2))
// saturated at 255, with frame_last set on the last interior result of the
// frame. border pixels give nothing. the front takes one pixel per clock as
// long as the four-entry gradient queue has room; the back unit pops one
// interior result at a time and takes no new one until it is through with it:
// two squares and an 8-step root on one shared multiplier, the root skipped
// when the sum of squares reaches 65536. a long run of interior pixels is thus
// paced by the back unit, border pixels add no work there, and a stalled edge
// channel holds it up. a write to image_width or image_height restarts the
// frame at row 0, column 0; sizes are clamped to 3..MAX_WIDTH and 3..4096.
// the line buffer ram needs no clearing pass: its entries only feed results
// once they have been written.
`default_nettype none

module sobel_edge_magnitude
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // configuration writes
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    // pixel channel
    input  wire logic                   pixel_valid,
    output logic                        pixel_stall,
    input  wire logic [PIX_W-1:0]       pixel,
    // result channel
    output logic                        edge_valid,
    input  wire logic                   edge_stall,
    output logic [PIX_W-1:0]            edge_value,
    output logic                        frame_last
);

    // front to queue
    logic       q_push;
    sem_grad_t  q_push_data;
    // queue to back
    logic       q_pop;
    sem_grad_t  q_head;
    sem_qstat_t q_stat;

    // intake, counters, line buffers, window and gradients
    sem_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .qstat       (q_stat),
        .q_push      (q_push),
        .q_data      (q_push_data)
    );

    // decouples pixel intake from the magnitude unit
    sem_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .head      (q_head),
        .qstat     (q_stat)
    );

    // magnitude unit with output register
    sem_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .qstat      (q_stat),
        .pop        (q_pop),
        .edge_valid (edge_valid),
        .edge_stall (edge_stall),
        .edge_value (edge_value),
        .frame_last (frame_last)
    );

`ifndef SYNTH
    // the intake stall must keep the queue from overflowing
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_stat.full)
        else $error("gradient queue overflow");

    // the back unit never pops an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_stat.empty)
        else $error("gradient queue underflow");

    // a full queue always holds off pixel intake
    assert property (@(posedge clk) disable iff (!rst_n) q_stat.full |-> pixel_stall)
        else $error("pixel intake open while queue is full");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_sobel_edge_magnitude.sv -----
// testbench for sobel_edge_magnitude: streams grayscale frames in raster order,
// predicts each interior edge magnitude and checks every edge transfer against it
// depends on sem_pkg and the sobel_edge_magnitude rtl
module tb_sobel_edge_magnitude;
    timeunit 1ns;
    timeprecision 1ps;

    import sem_pkg::*;

    // line buffer depth of the instance under test
    localparam int LINE_MAX = 1024;
    // cycles allowed after the last result before touching the registers:
    // slack for the block to settle once every expected result has been taken
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_ITEMS  = 1550;

    // register indexes past the end of the register list, writes are ignored
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

    // kinds of frame content
    typedef enum int
    {
        CONTENT_NOISE,
        CONTENT_SMOOTH,
        CONTENT_BINARY
    } content_t;

    // one expected edge transfer
    typedef struct
    {
        logic [PIX_W-1:0] magnitude;
        logic             last;
    } edge_result_t;

    // dut connections, every input known from time zero
    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   cfg_write   = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  cfg_data    = '0;
    logic                   pixel_valid = 1'b0;
    logic [PIX_W-1:0]       pixel       = '0;
    logic                   edge_stall  = 1'b0;
    logic                   pixel_stall;
    logic                   edge_valid;
    logic [PIX_W-1:0]       edge_value;
    logic                   frame_last;

    // idle rates of the two sides, in percent
    int src_idle_pct  = 17;
    int sink_idle_pct = 56;
    int failures      = 0;

    // expected edge transfers, oldest first
    edge_result_t pending_edges[$];

    // predictor state: registers, line buffers, window and raster position
    logic [WIDTH_FIELD_W-1:0]  model_width  = WIDTH_FIELD_W'(WIDTH_RESET);
    logic [HEIGHT_FIELD_W-1:0] model_height = HEIGHT_FIELD_W'(HEIGHT_RESET);
    logic [PIX_W-1:0]          row_two_up[0:LINE_MAX-1];
    logic [PIX_W-1:0]          row_one_up[0:LINE_MAX-1];
    logic [PIX_W-1:0]          window_px[0:8];
    int                        next_col = 0;
    int                        next_row = 0;

    sobel_edge_magnitude #(
        .MAX_WIDTH (LINE_MAX)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .edge_valid  (edge_valid),
        .edge_stall  (edge_stall),
        .edge_value  (edge_value),
        .frame_last  (frame_last)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // receiver side: stall decided afresh on every falling edge
    always @(negedge clk)
    begin
        edge_stall <= ($urandom_range(99) < sink_idle_pct);
    end

    // compare every edge transfer with the oldest expectation
    always @(posedge clk)
    begin
        edge_result_t want;
        if (rst_n && edge_valid && !edge_stall)
        begin
            if (pending_edges.size() == 0)
            begin
                $error("edge transfer with nothing expected: edge_value %0d frame_last %0d",
                       edge_value, frame_last);
                failures++;
            end
            else
            begin
                want = pending_edges.pop_front();
                if (edge_value !== want.magnitude)
                begin
                    $error("edge_value: expected %0d, got %0d", want.magnitude, edge_value);
                    failures++;
                end
                if (frame_last !== want.last)
                begin
                    $error("frame_last: expected %0d, got %0d", want.last, frame_last);
                    failures++;
                end
            end
        end
    end

    // hard stop if the run hangs
    initial
    begin
        #30_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic int clamp_size(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // advance the predictor by one accepted pixel, queue the result if any
    function automatic void predict_edge(input logic [PIX_W-1:0] px);
        int           w;
        int           h;
        int           gx;
        int           gy;
        int           sq;
        int           root;
        edge_result_t res;
        w = clamp_size(int'(model_width), SIZE_MIN, LINE_MAX);
        h = clamp_size(int'(model_height), SIZE_MIN, HEIGHT_MAX);

        // slide the window one column left, new column from the line buffers
        window_px[0] = window_px[1];
        window_px[1] = window_px[2];
        window_px[3] = window_px[4];
        window_px[4] = window_px[5];
        window_px[6] = window_px[7];
        window_px[7] = window_px[8];
        window_px[2] = row_two_up[next_col];
        window_px[5] = row_one_up[next_col];
        window_px[8] = px;
        row_two_up[next_col] = row_one_up[next_col];
        row_one_up[next_col] = px;

        // only interior pixels give a result
        if (next_row >= 2 && next_col >= 2)
        begin
            gx = int'(window_px[2]) + 2 * int'(window_px[5]) + int'(window_px[8])
               - int'(window_px[0]) - 2 * int'(window_px[3]) - int'(window_px[6]);
            gy = int'(window_px[6]) + 2 * int'(window_px[7]) + int'(window_px[8])
               - int'(window_px[0]) - 2 * int'(window_px[1]) - int'(window_px[2]);
            sq = gx * gx + gy * gy;
            // integer root, anything at or past 256 squared saturates
            if (sq >= 65536)
            begin
                root = 255;
            end
            else
            begin
                root = 0;
                while ((root + 1) * (root + 1) <= sq)
                begin
                    root++;
                end
            end
            res.magnitude = root[PIX_W-1:0];
            res.last      = (next_row == h - 1) && (next_col == w - 1);
            pending_edges.push_back(res);
        end

        // raster position, wraps to a new frame after the last row
        if (next_col + 1 >= w)
        begin
            next_col = 0;
            next_row = (next_row + 1 >= h) ? 0 : next_row + 1;
        end
        else
        begin
            next_col++;
        end
    endfunction

    function automatic logic [PIX_W-1:0] next_pixel(input content_t style,
                                                    input logic [PIX_W-1:0] base);
        case (style)
            CONTENT_SMOOTH: return base + PIX_W'($urandom_range(15)) - PIX_W'(8);
            CONTENT_BINARY: return $urandom_range(1) ? EDGE_MAX : '0;
            default:        return PIX_W'($urandom_range(255));
        endcase
    endfunction

    // one pixel transfer: random gap, then hold until accepted
    task automatic send_pixel(input logic [PIX_W-1:0] px);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            pixel_valid <= 1'b0;
            @(negedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= px;
        @(posedge clk);
        while (pixel_stall)
        begin
            @(posedge clk);
        end
        predict_edge(px);
    endtask

    // stop sending, wait for every expected result and let the back end settle
    task automatic drain_results();
        @(negedge clk);
        pixel_valid <= 1'b0;
        while (pending_edges.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write, only issued while the block is drained
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        // a write to a real register restarts the frame, spare indexes do nothing
        case (idx)
            REG_WIDTH:
            begin
                model_width = data[WIDTH_FIELD_W-1:0];
                next_col    = 0;
                next_row    = 0;
            end
            REG_HEIGHT:
            begin
                model_height = data[HEIGHT_FIELD_W-1:0];
                next_col     = 0;
                next_row     = 0;
            end
            default: ;
        endcase
    endtask

    task automatic send_frame(input int count, input content_t style);
        logic [PIX_W-1:0] base;
        base = PIX_W'($urandom_range(239, 16));
        repeat (count) send_pixel(next_pixel(style, base));
    endtask

    // reset geometry: two rows of 640 then a few interior pixels of row two
    task automatic test_reset_geometry();
        send_frame(2 * WIDTH_RESET + 6, CONTENT_SMOOTH);
        drain_results();
    endtask

    // hand-made 3x3 frames: a saturating step between black and white,
    // and a diagonal just under saturation (gx = gy = 180 gives 254)
    task automatic test_directed_frames();
        write_register(REG_WIDTH, 13'd3);
        write_register(REG_HEIGHT, 13'd3);
        repeat (3)
        begin
            send_pixel('0);
            send_pixel('0);
            send_pixel(EDGE_MAX);
        end
        send_pixel(8'd0);
        send_pixel(8'd0);
        send_pixel(8'd0);
        send_pixel(8'd0);
        send_pixel(8'd17);
        send_pixel(8'd90);
        send_pixel(8'd0);
        send_pixel(8'd90);
        send_pixel(8'd0);
        drain_results();
    endtask

    // writes past the register list must not restart the frame
    task automatic test_ignored_index();
        write_register(REG_WIDTH, 13'd4);
        write_register(REG_HEIGHT, 13'd3);
        send_frame(6, CONTENT_NOISE);
        drain_results();
        write_register(REG_SPARE_A, CFG_DATA_W'($urandom));
        write_register(REG_SPARE_B, '1);
        send_frame(6, CONTENT_NOISE);
        drain_results();
    endtask

    // sizes below 3 and above the maximum are clamped
    task automatic test_size_clamping();
        write_register(REG_WIDTH, '0);
        write_register(REG_HEIGHT, '0);
        send_frame(9, CONTENT_BINARY);
        drain_results();

        // bits above the width field are ignored
        write_register(REG_WIDTH, {2'b11, 11'd2});
        write_register(REG_HEIGHT, 13'd2);
        send_frame(9, CONTENT_SMOOTH);
        drain_results();

        // widest frame, every line buffer address used
        write_register(REG_WIDTH, CFG_DATA_W'(LINE_MAX));
        write_register(REG_HEIGHT, 13'd1);
        send_frame(3 * LINE_MAX, CONTENT_SMOOTH);
        drain_results();

        // all ones in both registers, width and height clamp high
        write_register(REG_WIDTH, '1);
        write_register(REG_HEIGHT, '1);
        send_frame(2 * LINE_MAX + 5, CONTENT_NOISE);
        drain_results();

        // narrowest width with the tallest height, frame never ends
        write_register(REG_WIDTH, 13'd3);
        write_register(REG_HEIGHT, CFG_DATA_W'(HEIGHT_MAX));
        send_frame(15, CONTENT_NOISE);
        drain_results();
    endtask

    // random small frames: mostly whole frames, some cut short by a new
    // geometry, some spare writes that leave the frame running, and the odd
    // mid-frame pause until everything has drained
    task automatic test_random_frames(input int src_pct, input int sink_pct,
                                      input int items);
        int                    sent;
        int                    w;
        int                    h;
        int                    count;
        int                    which;
        logic [CFG_DATA_W-1:0] data;
        content_t              style;
        logic [PIX_W-1:0]      base;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        sent          = 0;
        while (sent < items)
        begin
            drain_results();
            which = $urandom_range(99);
            if (which < 8)
            begin
                write_register($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B,
                               CFG_DATA_W'($urandom));
            end
            else
            begin
                // width only, height only, or both
                if (which < 90 || which >= 95)
                begin
                    data = CFG_DATA_W'($urandom);
                    data[WIDTH_FIELD_W-1:0] = ($urandom_range(99) < 5)
                        ? WIDTH_FIELD_W'($urandom_range(2))
                        : WIDTH_FIELD_W'($urandom_range(10, 3));
                    write_register(REG_WIDTH, data);
                end
                if (which < 95)
                begin
                    data = ($urandom_range(99) < 5) ? CFG_DATA_W'($urandom_range(2))
                                                    : CFG_DATA_W'($urandom_range(6, 3));
                    write_register(REG_HEIGHT, data);
                end
            end

            w     = clamp_size(int'(model_width), SIZE_MIN, LINE_MAX);
            h     = clamp_size(int'(model_height), SIZE_MIN, HEIGHT_MAX);
            count = $urandom_range(3, 1) * w * h;
            if ($urandom_range(99) < 25)
            begin
                count = $urandom_range(w * h - 1, 1);
            end
            style = content_t'($urandom_range(2));
            base  = PIX_W'($urandom_range(239, 16));
            repeat (count)
            begin
                if ($urandom_range(99) < 2)
                begin
                    drain_results();
                end
                send_pixel(next_pixel(style, base));
            end
            sent += count;
        end
    endtask

    initial
    begin
        for (int k = 0; k < LINE_MAX; k++)
        begin
            row_two_up[k] = '0;
            row_one_up[k] = '0;
        end
        for (int k = 0; k < 9; k++)
        begin
            window_px[k] = '0;
        end

        // reset held low from time zero, released away from the rising edge
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_geometry();
        test_directed_frames();
        test_ignored_index();
        test_size_clamping();
        test_random_frames(17, 56, RANDOM_ITEMS / 3);
        test_random_frames(56, 17, RANDOM_ITEMS / 3);
        test_random_frames(0, 0, RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        drain_results();

        if (failures == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
